// ===== sv/ppghr_pkg.sv =====
// shared constants and types for the pulse peak heart rate block
package ppghr_pkg;

  // field widths
  localparam int SAMPLE_BITS  = 18;
  localparam int COUNT_BITS   = 32;
  localparam int THRESH_BITS  = 18;
  localparam int SRATE_BITS   = 10;
  localparam int BPM_BITS     = 7;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DAT_BITS = 18;

  // serial scan length covers both the sample and the counter words
  localparam int SCAN_LEN = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;
  localparam int SCAN_W   = $clog2(SCAN_LEN);

  // rate numerator 60 * sample_rate_hz fits in this many bits
  localparam int NUM_BITS = SRATE_BITS + 6;
  localparam int QUO_BITS = NUM_BITS;

  localparam logic [BPM_BITS-1:0] BPM_MAX = {BPM_BITS{1'b1}};

  // reset values of the registers
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(50000);
  localparam logic [SRATE_BITS-1:0]  SRATE_RESET  = SRATE_BITS'(100);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_RATE = 2'd1;

  // divider request and answer
  typedef struct packed {
    logic                  start;
    logic [NUM_BITS-1:0]   num;
    logic [COUNT_BITS-1:0] den;
  } ppghr_div_ctrl_t;

  typedef struct packed {
    logic                done;
    logic [QUO_BITS-1:0] quot;
  } ppghr_div_status_t;

endpackage

// ===== sv/pulse_peak_heart_rate_top.sv =====
// pulse peak detector with heart rate estimate, bit-serial datapath
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  in       in_valid_i, in_stall_o, ir_sample_i       sink
//  out      out_valid_o, out_stall_i, beats_per_minute_o, peak_accepted_o  source
//  cfg      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i  sink
//
// each sample passes through the scan, decide and done states, the LSB-first scan
// of the 32-bit counter setting the scan length; an accepted peak adds the divide
// state for the one-bit-per-cycle divider.
// reset clears the state, counters and flags and loads the register defaults.
// the next sample is taken while a finished result waits on a stalled output;
// a result that finds the output register still full waits in the last state.
module pulse_peak_heart_rate_top import ppghr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_BITS-1:0]  ir_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BPM_BITS-1:0]     beats_per_minute_o,
  output logic                    peak_accepted_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DAT_BITS-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [THRESH_BITS-1:0] thr_cfg_q;
  logic [SRATE_BITS-1:0]  srate_cfg_q;

  logic [SAMPLE_BITS-1:0] cur_q, prev_q, thr_sr_q;
  logic [COUNT_BITS-1:0]  cnt_q, lp_q, per_q;
  logic [SRATE_BITS-1:0]  half_sr_q;
  logic [SCAN_W-1:0]      bit_q;
  logic                   carry_q, borrow_q;
  logic                   above_q, incr_q, pgt_q;
  logic                   rising_q, acc_q;
  logic [BPM_BITS-1:0]    rate_q;

  logic                   out_valid_q, peak_q;
  logic [BPM_BITS-1:0]    bpm_q;

  logic                   in_acc, out_free;
  logic                   smp_en, cnt_en, scan_last;
  logic                   cnt_bit, per_bit, borrow_d;
  logic                   take_peak;
  logic [NUM_BITS-1:0]    numer;
  logic [BPM_BITS-1:0]    rate_sat;

  ppghr_div_ctrl_t   div_ctrl;
  ppghr_div_status_t div_st;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_cfg_q   <= THRESH_RESET;
      srate_cfg_q <= SRATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:   thr_cfg_q   <= cfg_data_i[THRESH_BITS-1:0];
        CFG_SAMPLE_RATE: srate_cfg_q <= cfg_data_i[SRATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // which words still have bits left at this scan position
  always_comb begin
    smp_en    = ({1'b0, bit_q} < (SCAN_W + 1)'(SAMPLE_BITS));
    cnt_en    = ({1'b0, bit_q} < (SCAN_W + 1)'(COUNT_BITS));
    scan_last = (bit_q == SCAN_W'(SCAN_LEN - 1));
  end

  // serial increment of the counter and subtraction of the last peak count
  always_comb begin
    cnt_bit  = cnt_q[0] ^ carry_q;
    per_bit  = cnt_bit ^ lp_q[0] ^ borrow_q;
    borrow_d = (!cnt_bit && lp_q[0]) || (!(cnt_bit ^ lp_q[0]) && borrow_q);
  end

  // peak decision after the scan
  assign take_peak = above_q && !incr_q && rising_q && pgt_q;

  // 60 * rate as a shift and subtract
  assign numer = (NUM_BITS'(srate_cfg_q) << 6) - (NUM_BITS'(srate_cfg_q) << 2);

  // quotient clipped to the output range
  assign rate_sat = (div_st.quot > QUO_BITS'(BPM_MAX)) ? BPM_MAX
                                                       : div_st.quot[BPM_BITS-1:0];

  always_comb begin
    div_ctrl.start = (state_q == ST_DECIDE) && take_peak;
    div_ctrl.num   = numer;
    div_ctrl.den   = per_q;
  end

  ppghr_serial_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .status_o (div_st)
  );

  // state sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_DECIDE;
      ST_DECIDE: state_d = take_peak ? ST_DIV : ST_DONE;
      ST_DIV:    if (div_st.done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // scan shift registers for the sample side
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q    <= ir_sample_i;
      thr_sr_q <= SAMPLE_BITS'(thr_cfg_q);
    end else if ((state_q == ST_SCAN) && smp_en) begin
      cur_q    <= {1'b0, cur_q[SAMPLE_BITS-1:1]};
      thr_sr_q <= {1'b0, thr_sr_q[SAMPLE_BITS-1:1]};
    end
  end

  // period word and spacing limit
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      half_sr_q <= {1'b0, srate_cfg_q[SRATE_BITS-1:1]};
    end else if ((state_q == ST_SCAN) && cnt_en) begin
      half_sr_q <= {1'b0, half_sr_q[SRATE_BITS-1:1]};
      per_q     <= {per_bit, per_q[COUNT_BITS-1:1]};
    end
  end

  // block state, bit position and serial compare flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      cnt_q    <= '0;
      lp_q     <= '0;
      rising_q <= 1'b0;
      rate_q   <= '0;
      bit_q    <= '0;
      carry_q  <= 1'b0;
      borrow_q <= 1'b0;
      above_q  <= 1'b0;
      incr_q   <= 1'b0;
      pgt_q    <= 1'b0;
      acc_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            bit_q    <= '0;
            carry_q  <= 1'b1;
            borrow_q <= 1'b0;
            above_q  <= 1'b0;
            incr_q   <= 1'b0;
            pgt_q    <= 1'b0;
          end
        end
        ST_SCAN: begin
          bit_q <= scan_last ? '0 : bit_q + SCAN_W'(1);
          if (smp_en) begin
            above_q <= (cur_q[0] && !thr_sr_q[0]) || (!(cur_q[0] ^ thr_sr_q[0]) && above_q);
            incr_q  <= (cur_q[0] && !prev_q[0]) || (!(cur_q[0] ^ prev_q[0]) && incr_q);
            prev_q  <= {cur_q[0], prev_q[SAMPLE_BITS-1:1]};
          end
          if (cnt_en) begin
            cnt_q    <= {cnt_bit, cnt_q[COUNT_BITS-1:1]};
            lp_q     <= {lp_q[0], lp_q[COUNT_BITS-1:1]};
            carry_q  <= cnt_q[0] && carry_q;
            borrow_q <= borrow_d;
            pgt_q    <= (per_bit && !half_sr_q[0]) || (!(per_bit ^ half_sr_q[0]) && pgt_q);
          end
        end
        ST_DECIDE: begin
          acc_q <= take_peak;
          if (above_q) begin
            if (incr_q) begin
              rising_q <= 1'b1;
            end else if (rising_q) begin
              rising_q <= 1'b0;
              if (pgt_q) begin
                lp_q <= cnt_q;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            rate_q <= rate_sat;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      bpm_q  <= rate_q;
      peak_q <= acc_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign beats_per_minute_o = bpm_q;
  assign peak_accepted_o    = peak_q;

  // checks
  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN) && (bit_q == '0))
    else $error("accepted sample did not start the scan");

  a_decide_bit_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (bit_q == '0))
    else $error("scan position not cleared at decision");

  a_peak_updates_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free && acc_q) |=> (beats_per_minute_o == rate_q))
    else $error("accepted peak reported without the new rate");

endmodule

// ===== sv/ppghr_serial_div.sv =====
// restoring divider, one quotient bit per cycle
module ppghr_serial_div import ppghr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppghr_div_ctrl_t   ctrl_i,
  output ppghr_div_status_t status_o
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);
  localparam int CMP_W = ((COUNT_BITS > NUM_BITS) ? COUNT_BITS : NUM_BITS) + 1;

  logic [NUM_BITS-1:0]   num_q;
  logic [NUM_BITS-1:0]   rem_q, rem_d;
  logic [QUO_BITS-1:0]   quo_q;
  logic [COUNT_BITS-1:0] den_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  done_q;
  logic [NUM_BITS:0]     rem_shift;
  logic [CMP_W-1:0]      rem_ext, den_ext, diff;
  logic                  qbit;

  // trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    rem_shift = {rem_q, num_q[NUM_BITS-1]};
    rem_ext   = CMP_W'(rem_shift);
    den_ext   = CMP_W'(den_q);
    diff      = rem_ext - den_ext;
    qbit      = (rem_ext >= den_ext);
    rem_d     = qbit ? diff[NUM_BITS-1:0] : rem_shift[NUM_BITS-1:0];
  end

  // payload shift registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      num_q <= ctrl_i.num;
      den_q <= ctrl_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_BITS-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_BITS-2:0], qbit};
    end
  end

  // iteration count and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (ctrl_i.start) begin
      cnt_q  <= CNT_W'(NUM_BITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign status_o.done = done_q;
  assign status_o.quot = quo_q;

endmodule
